// File: src/jstg_pkg.sv
`default_nettype none

package jstg_pkg;

  // Field widths
  localparam int unsigned ANGLE_W  = 16;  // Q3.12 angles
  localparam int unsigned AMP_W    = 15;  // amplitude, unsigned Q3.12
  localparam int unsigned RATE_W   = 16;  // omega, unsigned Q4.12
  localparam int unsigned TURN_W   = 32;  // phase registers, full scale one turn
  localparam int unsigned TICK_W   = 32;
  localparam int unsigned VEL_W    = 16;  // velocity, Q7.8
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;

  // Defaults for top level parameters
  localparam int unsigned PHASE_BITS_DEF      = 32;
  localparam int unsigned SINE_ITERATIONS_DEF = 16;

  // Position saturation range before the limit clip
  localparam int unsigned POSITION_BITS = 16;
  localparam int unsigned RAW_W = 34;
  localparam logic signed [RAW_W-1:0] POS_MAX =
    RAW_W'((longint'(1) << (POSITION_BITS - 1)) - 1);
  localparam logic signed [RAW_W-1:0] POS_MIN = -POS_MAX - RAW_W'(1);

  // sin/cos results, Q1.30
  localparam int unsigned SC_W = 32;
  localparam longint CORDIC_GAIN = 64'd652032874;
  localparam longint ONE_Q30     = 64'd1073741824;
  localparam int unsigned ATAN_IDX_W = 5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESET   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_DURATION = 3'd7;

  // Register reset values
  localparam logic signed [ANGLE_W-1:0] CENTER_RST = 16'sd0;
  localparam logic signed [ANGLE_W-1:0] LOWER_RST  = -16'sd12868;
  localparam logic signed [ANGLE_W-1:0] UPPER_RST  = 16'sd12868;
  localparam logic [AMP_W-1:0]          PRESET_RST = 15'd1638;
  localparam logic [TURN_W-1:0]         STEP_RST   = 32'd3865471;
  localparam logic [TURN_W-1:0]         OFFSET_RST = 32'd0;
  localparam logic [RATE_W-1:0]         RATE_RST   = 16'd11581;
  localparam logic [TICK_W-1:0]         DURATION_RST = 32'd300000;

  // atan(2^-i) in turns, 2^32 = one turn
  function automatic logic [31:0] atan_turns(input logic [ATAN_IDX_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10680350;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: src/joint_sine_trajectory_generator_top.sv
`default_nettype none

// Channel  | Handshake                 | Payload
// ---------+---------------------------+-----------------------------------------
// cfg      | cfg_we_i                  | cfg_index_i, cfg_data_i
// in       | in_valid_i / in_stall_o   | restart_i, stop_request_i
// out      | out_valid_o / out_stall_i | position_command_o, velocity_command_o,
//          |                           | at_limit_o, center_out_of_range_o, finished_o
//
// A running tick runs the CORDIC loop, then a 16-bit serial omega*cos multiply,
// then two 15-bit serial amplitude multiplies side by side; the divide-by-five
// starts with the CORDIC and the amplitude multiplies wait for it. A finished tick
// goes straight to the output state. One tick is in work at a time; the result
// register lets the next tick be taken while a result waits on out_stall_i.
// Reset is asynchronous, active low, and loads the register defaults.
module joint_sine_trajectory_generator_top #(
  parameter int unsigned PHASE_BITS      = jstg_pkg::PHASE_BITS_DEF,
  parameter int unsigned SINE_ITERATIONS = jstg_pkg::SINE_ITERATIONS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic        [jstg_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic        [jstg_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic                                  restart_i,
  input  wire logic                                  stop_request_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic signed      [jstg_pkg::ANGLE_W-1:0]   position_command_o,
  output logic signed      [jstg_pkg::VEL_W-1:0]     velocity_command_o,
  output logic                                       at_limit_o,
  output logic                                       center_out_of_range_o,
  output logic                                       finished_o
);

  localparam int unsigned AW   = jstg_pkg::ANGLE_W;
  localparam int unsigned TW   = jstg_pkg::TURN_W;
  localparam int unsigned RW   = jstg_pkg::RAW_W;
  localparam int unsigned SCW  = jstg_pkg::SC_W;
  localparam int unsigned AMPW = jstg_pkg::AMP_W;
  localparam int unsigned RTW  = jstg_pkg::RATE_W;
  localparam int unsigned WW   = SCW + RTW;    // omega*cos
  localparam int unsigned PSW  = SCW + AMPW;   // amp*sin
  localparam int unsigned PVW  = WW + AMPW;    // amp*omega*cos

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CORD = 3'd1;
  localparam logic [2:0] S_MULW = 3'd2;
  localparam logic [2:0] S_MULP = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  // configuration registers
  logic signed [AW-1:0]   center_q, lower_q, upper_q;
  logic [AMPW-1:0]        preset_q;
  logic [TW-1:0]          step_q, offset_q;
  logic [RTW-1:0]         rate_q;
  logic [jstg_pkg::TICK_W-1:0] duration_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q   <= jstg_pkg::CENTER_RST;
      lower_q    <= jstg_pkg::LOWER_RST;
      upper_q    <= jstg_pkg::UPPER_RST;
      preset_q   <= jstg_pkg::PRESET_RST;
      step_q     <= jstg_pkg::STEP_RST;
      offset_q   <= jstg_pkg::OFFSET_RST;
      rate_q     <= jstg_pkg::RATE_RST;
      duration_q <= jstg_pkg::DURATION_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        jstg_pkg::CFG_CENTER:   center_q   <= cfg_data_i[AW-1:0];
        jstg_pkg::CFG_LOWER:    lower_q    <= cfg_data_i[AW-1:0];
        jstg_pkg::CFG_UPPER:    upper_q    <= cfg_data_i[AW-1:0];
        jstg_pkg::CFG_PRESET:   preset_q   <= cfg_data_i[AMPW-1:0];
        jstg_pkg::CFG_STEP:     step_q     <= cfg_data_i[TW-1:0];
        jstg_pkg::CFG_OFFSET:   offset_q   <= cfg_data_i[TW-1:0];
        jstg_pkg::CFG_RATE:     rate_q     <= cfg_data_i[RTW-1:0];
        jstg_pkg::CFG_DURATION: duration_q <= cfg_data_i[jstg_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // tick state and control
  logic [2:0]             state_q;
  logic [PHASE_BITS-1:0]  acc_q;
  logic [jstg_pkg::TICK_W-1:0] tick_q;
  logic                   done_q;
  logic                   fin_q;

  logic accept, done_now, go;
  logic [PHASE_BITS-1:0]  phase_eff, step_acc, offs_acc, phase_sum;
  logic [jstg_pkg::TICK_W-1:0] tick_eff;
  logic                   done_eff;
  logic [PHASE_BITS+TW-1:0] step_w, offs_w, theta_w;
  logic [TW-1:0]          theta;

  assign accept = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);

  // restart first, then the finish test; turns are aligned to the accumulator
  always_comb begin
    phase_eff = restart_i ? '0 : acc_q;
    tick_eff  = restart_i ? '0 : tick_q;
    done_eff  = restart_i ? 1'b0 : done_q;
    done_now  = done_eff || stop_request_i || (tick_eff >= duration_q);
    go        = accept && !done_now;
    step_w    = {step_q, {PHASE_BITS{1'b0}}};
    offs_w    = {offset_q, {PHASE_BITS{1'b0}}};
    step_acc  = step_w[PHASE_BITS+TW-1:TW];
    offs_acc  = offs_w[PHASE_BITS+TW-1:TW];
    phase_sum = phase_eff + offs_acc;
    theta_w   = {phase_sum, {TW{1'b0}}};
    theta     = theta_w[PHASE_BITS+TW-1:PHASE_BITS];
  end

  // arithmetic units
  logic amp_busy, cord_busy, mulw_busy, muls_busy, mulv_busy;
  logic mulw_go, mulp_go;
  logic [AMPW-1:0]        amp;
  logic signed [SCW-1:0]  sin_v, cos_v;
  logic signed [WW-1:0]   w_cos;
  logic signed [PSW-1:0]  p_sin;
  logic signed [PVW-1:0]  p_vel;

  assign mulw_go = (state_q == S_CORD) && !cord_busy;
  assign mulp_go = (state_q == S_MULW) && !mulw_busy && !amp_busy;

  jstg_amp u_amp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (go),
    .center_i (center_q),
    .lower_i  (lower_q),
    .upper_i  (upper_q),
    .preset_i (preset_q),
    .busy_o   (amp_busy),
    .amp_o    (amp)
  );

  jstg_cordic #(.ITERS(SINE_ITERATIONS)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (go),
    .turns_i (theta),
    .busy_o  (cord_busy),
    .sin_o   (sin_v),
    .cos_o   (cos_v)
  );

  jstg_smul #(.A_W(SCW), .B_W(RTW)) u_mul_w (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mulw_go),
    .a_i     (cos_v),
    .b_i     (rate_q),
    .busy_o  (mulw_busy),
    .p_o     (w_cos)
  );

  jstg_smul #(.A_W(SCW), .B_W(AMPW)) u_mul_s (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mulp_go),
    .a_i     (sin_v),
    .b_i     (amp),
    .busy_o  (muls_busy),
    .p_o     (p_sin)
  );

  jstg_smul #(.A_W(WW), .B_W(AMPW)) u_mul_v (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mulp_go),
    .a_i     (w_cos),
    .b_i     (amp),
    .busy_o  (mulv_busy),
    .p_o     (p_vel)
  );

  // round half up, saturate
  logic signed [PSW:0]     ps_ext;
  logic signed [PSW-30:0]  rnd_s;
  logic signed [RW-1:0]    raw_full, raw_sat, raw_q;
  logic signed [PVW:0]     pv_ext;
  logic signed [PVW-46:0]  rnd_v;
  logic signed [jstg_pkg::VEL_W-1:0] vel_sat, vel_q;

  always_comb begin
    ps_ext   = {p_sin[PSW-1], p_sin} + (PSW+1)'(64'd536870912);
    rnd_s    = ps_ext[PSW:30];
    raw_full = {{(RW-AW){center_q[AW-1]}}, center_q}
             + {{(RW-(PSW-29)){rnd_s[PSW-30]}}, rnd_s};
    raw_sat  = (raw_full > jstg_pkg::POS_MAX) ? jstg_pkg::POS_MAX :
               ((raw_full < jstg_pkg::POS_MIN) ? jstg_pkg::POS_MIN : raw_full);
    pv_ext   = {p_vel[PVW-1], p_vel} + (PVW+1)'(64'd35184372088832);
    rnd_v    = pv_ext[PVW:46];
    if (rnd_v > (PVW-45)'(32767)) begin
      vel_sat = 16'sh7FFF;
    end else if (rnd_v < -(PVW-45)'(32768)) begin
      vel_sat = 16'sh8000;
    end else begin
      vel_sat = rnd_v[jstg_pkg::VEL_W-1:0];
    end
  end

  // limit clip on the rounded position
  logic signed [RW-1:0] lo_ext, hi_ext, pos_up, pos_cl;
  logic                 lim, center_oor, slot_free, load;

  always_comb begin
    lo_ext     = {{(RW-AW){lower_q[AW-1]}}, lower_q};
    hi_ext     = {{(RW-AW){upper_q[AW-1]}}, upper_q};
    pos_up     = (raw_q < hi_ext) ? raw_q : hi_ext;
    pos_cl     = (pos_up < lo_ext) ? lo_ext : pos_up;
    lim        = (pos_cl <= lo_ext) || (pos_cl >= hi_ext);
    center_oor = (center_q < lower_q) || (center_q > upper_q);
    slot_free  = !out_valid_o || !out_stall_i;
    load       = (state_q == S_OUT) && slot_free;
  end

  // sequencer and tick state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      acc_q   <= '0;
      tick_q  <= '0;
      done_q  <= 1'b0;
      fin_q   <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            done_q <= done_now;
            fin_q  <= done_now;
            if (done_now) begin
              acc_q   <= phase_eff;
              tick_q  <= tick_eff;
              state_q <= S_OUT;
            end else begin
              acc_q   <= phase_eff + step_acc;
              tick_q  <= tick_eff + jstg_pkg::TICK_W'(1);
              state_q <= S_CORD;
            end
          end
        end
        S_CORD: if (mulw_go) state_q <= S_MULW;
        S_MULW: if (mulp_go) state_q <= S_MULP;
        S_MULP: if (!muls_busy && !mulv_busy) state_q <= S_OUT;
        S_OUT:  if (slot_free) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_MULP) && !muls_busy && !mulv_busy) begin
      raw_q <= raw_sat;
      vel_q <= vel_sat;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (load) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      center_out_of_range_o <= center_oor;
      finished_o            <= fin_q;
      if (fin_q) begin
        position_command_o <= center_q;
        velocity_command_o <= '0;
        at_limit_o         <= 1'b0;
      end else begin
        position_command_o <= pos_cl[AW-1:0];
        velocity_command_o <= lim ? '0 : vel_q;
        at_limit_o         <= lim;
      end
    end
  end

  // checks
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !(amp_busy || cord_busy || mulw_busy || muls_busy || mulv_busy))
    else $error("arithmetic unit busy while idle");

  a_go_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go |=> (state_q == S_CORD) && cord_busy && amp_busy)
    else $error("running tick did not start the CORDIC and divider");

  a_limit_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && at_limit_o |-> (velocity_command_o == '0))
    else $error("nonzero velocity at a limit");

  a_finished_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && finished_o |-> (velocity_command_o == '0) && !at_limit_o)
    else $error("finished result carries motion");

endmodule

`default_nettype wire

// File: src/jstg_amp.sv
`default_nettype none

// Safe amplitude: min(preset, floor(4*d/5)) with d the nearer limit distance,
// zero when d <= 0. Restoring division by five, one quotient bit per cycle.
module jstg_amp (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  input  wire logic signed [jstg_pkg::ANGLE_W-1:0]  center_i,
  input  wire logic signed [jstg_pkg::ANGLE_W-1:0]  lower_i,
  input  wire logic signed [jstg_pkg::ANGLE_W-1:0]  upper_i,
  input  wire logic        [jstg_pkg::AMP_W-1:0]    preset_i,
  output logic                                      busy_o,
  output logic             [jstg_pkg::AMP_W-1:0]    amp_o
);

  localparam int unsigned AW    = jstg_pkg::ANGLE_W;
  localparam int unsigned DW    = AW + 2;            // dividend 4*d
  localparam int unsigned CNT_W = $clog2(DW + 1);
  localparam logic [3:0]  DIVISOR = 4'd5;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [2:0]       rem_q, rem_d;
  logic [DW-1:0]    num_q, num_d;

  logic signed [AW:0] dist_hi, dist_lo, dist_min;
  logic [3:0]         trial;
  logic               fits;

  // nearer distance at start
  always_comb begin
    dist_hi  = {upper_i[AW-1], upper_i} - {center_i[AW-1], center_i};
    dist_lo  = {center_i[AW-1], center_i} - {lower_i[AW-1], lower_i};
    dist_min = (dist_lo < dist_hi) ? dist_lo : dist_hi;
  end

  // one quotient bit: dividend shifts out on top, quotient shifts in below
  always_comb begin
    trial = {rem_q, num_q[DW-1]};
    fits  = (trial >= DIVISOR);
    rem_d = fits ? 3'(trial - DIVISOR) : trial[2:0];
    num_d = {num_q[DW-2:0], fits};
    cnt_d = cnt_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNT_W'(DW);
    end else if (busy_o) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      num_q <= (dist_min > 0) ? {dist_min[AW-1:0], 2'b00} : '0;
    end else if (busy_o) begin
      rem_q <= rem_d;
      num_q <= num_d;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign amp_o  = (num_q > DW'(preset_i)) ? preset_i : num_q[jstg_pkg::AMP_W-1:0];

endmodule

`default_nettype wire

// File: src/jstg_cordic.sv
`default_nettype none

// Iterative rotation CORDIC, one micro-rotation per cycle over the
// quadrant residue, gain preloaded, results clamped to +-1.0 (Q1.30).
module jstg_cordic #(
  parameter int unsigned ITERS = jstg_pkg::SINE_ITERATIONS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  input  wire logic        [jstg_pkg::TURN_W-1:0] turns_i,
  output logic                                    busy_o,
  output logic signed      [jstg_pkg::SC_W-1:0]   sin_o,
  output logic signed      [jstg_pkg::SC_W-1:0]   cos_o
);

  localparam int unsigned XW = jstg_pkg::SC_W + 2;
  localparam int unsigned ZW = jstg_pkg::TURN_W + 1;
  localparam int unsigned IW = jstg_pkg::ATAN_IDX_W;
  localparam logic signed [XW-1:0] ONE  = XW'(jstg_pkg::ONE_Q30);
  localparam logic signed [XW-1:0] GAIN = XW'(jstg_pkg::CORDIC_GAIN);
  localparam logic [IW-1:0] LAST = IW'(ITERS - 1);
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  logic              busy_q;
  logic [IW-1:0]     idx_q;
  logic signed [XW-1:0] x_q, y_q, x_d, y_d;
  logic signed [ZW-1:0] z_q, z_d;
  logic [1:0]        quad_q;

  logic signed [XW-1:0] x_sh, y_sh, x_cl, y_cl;
  logic signed [ZW-1:0] ang;
  logic signed [jstg_pkg::SC_W-1:0] xs, ys;

  // micro-rotation
  always_comb begin
    x_sh = x_q >>> idx_q;
    y_sh = y_q >>> idx_q;
    ang  = ZW'(jstg_pkg::atan_turns(idx_q));
    if (!z_q[ZW-1]) begin
      x_d = x_q - y_sh;
      y_d = y_q + x_sh;
      z_d = z_q - ang;
    end else begin
      x_d = x_q + y_sh;
      y_d = y_q - x_sh;
      z_d = z_q + ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (busy_q) begin
      busy_q <= (idx_q != LAST);
      idx_q  <= idx_q + IW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= GAIN;
      y_q    <= '0;
      z_q    <= ZW'(turns_i[jstg_pkg::TURN_W-3:0]);
      quad_q <= turns_i[jstg_pkg::TURN_W-1:jstg_pkg::TURN_W-2];
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  // clamp and fold back into the full turn
  always_comb begin
    x_cl = (x_q > ONE) ? ONE : ((x_q < -ONE) ? -ONE : x_q);
    y_cl = (y_q > ONE) ? ONE : ((y_q < -ONE) ? -ONE : y_q);
    xs   = x_cl[jstg_pkg::SC_W-1:0];
    ys   = y_cl[jstg_pkg::SC_W-1:0];
    case (quad_q)
      QUAD_0:  begin sin_o = ys;  cos_o = xs;  end
      QUAD_1:  begin sin_o = xs;  cos_o = -ys; end
      QUAD_2:  begin sin_o = -ys; cos_o = -xs; end
      default: begin sin_o = -xs; cos_o = ys;  end
    endcase
  end

  assign busy_o = busy_q;

endmodule

`default_nettype wire

// File: src/jstg_smul.sv
`default_nettype none

// Bit-serial shift-add multiplier: signed a times unsigned b,
// one bit of b per cycle, LSB first.
module jstg_smul #(
  parameter int unsigned A_W = 32,
  parameter int unsigned B_W = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic signed [A_W-1:0]   a_i,
  input  wire logic        [B_W-1:0]   b_i,
  output logic                         busy_o,
  output logic signed [A_W+B_W-1:0]    p_o
);

  localparam int unsigned CNT_W = $clog2(B_W + 1);

  logic [CNT_W-1:0]     cnt_q;
  logic signed [A_W-1:0] a_q;
  logic signed [A_W:0]  hi_q, sum;
  logic [B_W-1:0]       lo_q;

  // add partial product, then shift the pair right one place
  always_comb begin
    sum = hi_q + (lo_q[0] ? {a_q[A_W-1], a_q} : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNT_W'(B_W);
    end else if (busy_o) begin
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      hi_q <= '0;
      lo_q <= b_i;
    end else if (busy_o) begin
      hi_q <= sum >>> 1;
      lo_q <= {sum[0], lo_q[B_W-1:1]};
    end
  end

  assign busy_o = (cnt_q != '0);
  assign p_o    = {hi_q[A_W-1:0], lo_q};

endmodule

`default_nettype wire

// File: bench/joint_sine_trajectory_generator_top_tb.sv
`default_nettype none

module joint_sine_trajectory_generator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned DRAIN_CYCLES   = jstg_pkg::SINE_ITERATIONS_DEF + 44;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_PHASES  = 6;
  localparam int unsigned PHASE_TICKS    = 105;
  localparam longint      POS_HI = (longint'(1) << (jstg_pkg::POSITION_BITS - 1)) - 1;
  localparam longint      POS_LO = -POS_HI - 1;

  typedef logic [jstg_pkg::CFG_IDX_W-1:0] cfg_idx_t;

  typedef enum logic [1:0] {
    ITEM_TICK,
    ITEM_WRITE,
    ITEM_HOLD
  } item_kind_e;

  typedef struct packed {
    item_kind_e      kind;
    logic            restart;
    logic            stop;
    logic            calm;
    cfg_idx_t        idx;
    logic [jstg_pkg::CFG_W-1:0] data;
  } plan_item_t;

  typedef struct packed {
    logic signed [jstg_pkg::ANGLE_W-1:0] pos;
    logic signed [jstg_pkg::VEL_W-1:0]   vel;
    logic                                lim;
    logic                                cor;
    logic                                fin;
  } traj_sample_t;

  // DUT signals
  logic                                clk_i          = 1'b0;
  logic                                rst_ni         = 1'b0;
  logic                                cfg_we_i       = 1'b0;
  cfg_idx_t                            cfg_index_i    = '0;
  logic [jstg_pkg::CFG_W-1:0]          cfg_data_i     = '0;
  logic                                in_valid_i     = 1'b0;
  logic                                in_stall_o;
  logic                                restart_i      = 1'b0;
  logic                                stop_request_i = 1'b0;
  logic                                out_valid_o;
  logic                                out_stall_i    = 1'b0;
  logic signed [jstg_pkg::ANGLE_W-1:0] position_command_o;
  logic signed [jstg_pkg::VEL_W-1:0]   velocity_command_o;
  logic                                at_limit_o;
  logic                                center_out_of_range_o;
  logic                                finished_o;

  // Predictor copy of registers and joint state
  logic signed [jstg_pkg::ANGLE_W-1:0] center_q;
  logic signed [jstg_pkg::ANGLE_W-1:0] lower_q;
  logic signed [jstg_pkg::ANGLE_W-1:0] upper_q;
  logic [jstg_pkg::AMP_W-1:0]          preset_q;
  logic [jstg_pkg::TURN_W-1:0]         step_q;
  logic [jstg_pkg::TURN_W-1:0]         offset_q;
  logic [jstg_pkg::RATE_W-1:0]         rate_q;
  logic [jstg_pkg::TICK_W-1:0]         duration_q;
  logic [jstg_pkg::TURN_W-1:0]         phase_acc;
  logic [jstg_pkg::TICK_W-1:0]         tick_cnt;
  logic                                done_q;

  // Rotation angles atan(2^-i), one turn = 2^32
  longint rot_turns [0:15] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10680350, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861
  };

  plan_item_t   tick_plan [$];
  traj_sample_t sample_fifo [$];

  int unsigned gap_left     = 0;
  int unsigned stall_left   = 0;
  int unsigned settle_cnt   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned beat_cnt     = 0;
  int unsigned err_cnt      = 0;
  logic        calm_q       = 1'b0;

  joint_sine_trajectory_generator_top i_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_index_i           (cfg_index_i),
    .cfg_data_i            (cfg_data_i),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .restart_i             (restart_i),
    .stop_request_i        (stop_request_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .position_command_o    (position_command_o),
    .velocity_command_o    (velocity_command_o),
    .at_limit_o            (at_limit_o),
    .center_out_of_range_o (center_out_of_range_o),
    .finished_o            (finished_o)
  );

  // Clock and reset
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  task automatic report_mismatch(input string field, input longint want, input longint got);
    $display("mismatch in %s at result beat %0d: expected %0d, got %0d",
             field, beat_cnt, want, got);
    err_cnt++;
  endtask

  task automatic add_tick(input logic restart, input logic stop, input logic calm);
    plan_item_t it;
    it = '{kind: ITEM_TICK, restart: restart, stop: stop, calm: calm, idx: '0, data: '0};
    tick_plan.push_back(it);
  endtask

  task automatic add_write(input cfg_idx_t idx, input logic [jstg_pkg::CFG_W-1:0] data);
    plan_item_t it;
    it = '{kind: ITEM_WRITE, restart: 1'b0, stop: 1'b0, calm: 1'b0, idx: idx, data: data};
    tick_plan.push_back(it);
  endtask

  // One control tick of the joint: expected outputs and state update
  function automatic traj_sample_t advance_trajectory(input logic restart, input logic stop);
    traj_sample_t s;
    longint c, lo, hi, d, amp, sn, cs, raw, pos, vel;
    longint x, y, z, nx;
    logic [jstg_pkg::TURN_W-1:0] turns;
    logic lim;
    c  = center_q;
    lo = lower_q;
    hi = upper_q;
    if (restart) begin
      phase_acc = '0;
      tick_cnt  = '0;
      done_q    = 1'b0;
    end
    if (stop || tick_cnt >= duration_q) done_q = 1'b1;
    s.cor = (c < lo || c > hi);
    if (done_q) begin
      s.pos = center_q;
      s.vel = '0;
      s.lim = 1'b0;
      s.fin = 1'b1;
      return s;
    end

    // safe amplitude
    d = hi - c;
    if (c - lo < d) d = c - lo;
    amp = (4 * d) / 5;
    if (amp < 0) amp = 0;
    if (amp > longint'(preset_q)) amp = longint'(preset_q);

    // CORDIC over the quadrant residue, then quadrant mapping
    turns = phase_acc + offset_q;
    x = jstg_pkg::CORDIC_GAIN;
    y = 0;
    z = longint'(turns & 32'h3FFF_FFFF);
    for (int i = 0; i < jstg_pkg::SINE_ITERATIONS_DEF; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - rot_turns[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + rot_turns[i];
      end
      x = nx;
    end
    if (x > jstg_pkg::ONE_Q30) x = jstg_pkg::ONE_Q30;
    if (x < -jstg_pkg::ONE_Q30) x = -jstg_pkg::ONE_Q30;
    if (y > jstg_pkg::ONE_Q30) y = jstg_pkg::ONE_Q30;
    if (y < -jstg_pkg::ONE_Q30) y = -jstg_pkg::ONE_Q30;
    case (turns[31:30])
      2'd0:    begin sn = y;  cs = x;  end
      2'd1:    begin sn = x;  cs = -y; end
      2'd2:    begin sn = -y; cs = -x; end
      default: begin sn = -x; cs = y;  end
    endcase

    // position: round half up, saturate, clip to limits
    raw = c + ((amp * sn + (longint'(1) << 29)) >>> 30);
    if (raw > POS_HI) raw = POS_HI;
    if (raw < POS_LO) raw = POS_LO;
    pos = (raw < hi) ? raw : hi;
    if (pos < lo) pos = lo;
    lim = (pos <= lo || pos >= hi);

    // velocity: Q7.8, saturated, zero at a limit
    vel = (amp * longint'(rate_q) * cs + (longint'(1) << 45)) >>> 46;
    if (vel > 32767) vel = 32767;
    if (vel < -32768) vel = -32768;
    if (lim) vel = 0;

    s.pos = pos[jstg_pkg::ANGLE_W-1:0];
    s.vel = vel[jstg_pkg::VEL_W-1:0];
    s.lim = lim;
    s.fin = 1'b0;
    phase_acc = phase_acc + step_q;
    tick_cnt  = tick_cnt + 1;
    return s;
  endfunction

  // Driver: input beats, register writes and holds, fed from the plan
  always @(posedge clk_i) begin : driver
    plan_item_t head;
    logic valid_nxt;
    logic we_nxt;
    valid_nxt = in_valid_i;
    we_nxt    = 1'b0;
    if (!rst_ni) begin
      center_q   = jstg_pkg::CENTER_RST;
      lower_q    = jstg_pkg::LOWER_RST;
      upper_q    = jstg_pkg::UPPER_RST;
      preset_q   = jstg_pkg::PRESET_RST;
      step_q     = jstg_pkg::STEP_RST;
      offset_q   = jstg_pkg::OFFSET_RST;
      rate_q     = jstg_pkg::RATE_RST;
      duration_q = jstg_pkg::DURATION_RST;
      phase_acc  = '0;
      tick_cnt   = '0;
      done_q     = 1'b0;
      valid_nxt  = 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        sample_fifo.push_back(advance_trajectory(restart_i, stop_request_i));
        valid_nxt  = 1'b0;
        settle_cnt = 0;
        if (!calm_q && $urandom_range(0, 2) == 0) gap_left = $urandom_range(1, 3);
      end
      if (!valid_nxt && gap_left > 0) begin
        gap_left--;
      end else if (!valid_nxt && tick_plan.size() > 0) begin
        head = tick_plan[0];
        case (head.kind)
          ITEM_TICK: begin
            void'(tick_plan.pop_front());
            valid_nxt = 1'b1;
            restart_i      <= head.restart;
            stop_request_i <= head.stop;
            calm_q         <= head.calm;
          end
          ITEM_WRITE: begin
            // registers change only once the block has drained
            if (sample_fifo.size() == 0) begin
              if (settle_cnt < SETTLE_CYCLES) begin
                settle_cnt++;
              end else begin
                void'(tick_plan.pop_front());
                we_nxt = 1'b1;
                cfg_index_i <= head.idx;
                cfg_data_i  <= head.data;
                case (head.idx)
                  jstg_pkg::CFG_CENTER:   center_q   = head.data[jstg_pkg::ANGLE_W-1:0];
                  jstg_pkg::CFG_LOWER:    lower_q    = head.data[jstg_pkg::ANGLE_W-1:0];
                  jstg_pkg::CFG_UPPER:    upper_q    = head.data[jstg_pkg::ANGLE_W-1:0];
                  jstg_pkg::CFG_PRESET:   preset_q   = head.data[jstg_pkg::AMP_W-1:0];
                  jstg_pkg::CFG_STEP:     step_q     = head.data[jstg_pkg::TURN_W-1:0];
                  jstg_pkg::CFG_OFFSET:   offset_q   = head.data[jstg_pkg::TURN_W-1:0];
                  jstg_pkg::CFG_RATE:     rate_q     = head.data[jstg_pkg::RATE_W-1:0];
                  jstg_pkg::CFG_DURATION: duration_q = head.data[jstg_pkg::TICK_W-1:0];
                  default: ;
                endcase
              end
            end
          end
          default: begin
            // sender holds off until every pending result is back
            if (sample_fifo.size() == 0) void'(tick_plan.pop_front());
          end
        endcase
      end
    end
    in_valid_i <= valid_nxt;
    cfg_we_i   <= we_nxt;
  end

  // Monitor: compare result beats, random stall bursts
  always @(posedge clk_i) begin : monitor
    traj_sample_t want;
    logic stall_nxt;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (sample_fifo.size() == 0) begin
          report_mismatch("unexpected result beat", 0, 1);
        end else begin
          want = sample_fifo.pop_front();
          if (position_command_o !== want.pos)
            report_mismatch("position_command", want.pos, position_command_o);
          if (velocity_command_o !== want.vel)
            report_mismatch("velocity_command", want.vel, velocity_command_o);
          if (at_limit_o !== want.lim)
            report_mismatch("at_limit", want.lim, at_limit_o);
          if (center_out_of_range_o !== want.cor)
            report_mismatch("center_out_of_range", want.cor, center_out_of_range_o);
          if (finished_o !== want.fin)
            report_mismatch("finished", want.fin, finished_o);
        end
        beat_cnt++;
      end
      stall_nxt = 1'b0;
      if (stall_left > 0) begin
        stall_left--;
        stall_nxt = 1'b1;
      end else if (!calm_q && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 2);
        stall_nxt  = 1'b1;
      end
      out_stall_i <= stall_nxt;
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", quiet_cycles);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus plan and end of run
  initial begin : stimulus
    int  lo, hi, ctr, r;
    logic last, calm;

    // reset settings: motion, stop, hold while finished, restart
    add_tick(1'b0, 1'b0, 1'b0);
    add_tick(1'b0, 1'b0, 1'b0);
    add_tick(1'b0, 1'b1, 1'b0);
    add_tick(1'b0, 1'b0, 1'b0);
    add_tick(1'b1, 1'b0, 1'b0);
    add_tick(1'b1, 1'b1, 1'b0);
    add_tick(1'b1, 1'b0, 1'b0);

    // widest limits, center at the upper limit
    add_write(jstg_pkg::CFG_LOWER, 32'h0000_8000);
    add_write(jstg_pkg::CFG_UPPER, 32'h0000_7FFF);
    add_write(jstg_pkg::CFG_PRESET, 32'h0000_7FFF);
    add_write(jstg_pkg::CFG_STEP, 32'h4000_0000);
    add_write(jstg_pkg::CFG_OFFSET, 32'hFFFF_FFFF);
    add_write(jstg_pkg::CFG_RATE, 32'h0000_FFFF);
    add_write(jstg_pkg::CFG_DURATION, 32'hFFFF_FFFF);
    add_write(jstg_pkg::CFG_CENTER, 32'h0000_7FFF);
    add_tick(1'b1, 1'b0, 1'b0);
    add_tick(1'b0, 1'b0, 1'b0);
    // center at the lower limit
    add_write(jstg_pkg::CFG_CENTER, 32'h0000_8000);
    add_tick(1'b0, 1'b0, 1'b0);
    add_tick(1'b0, 1'b0, 1'b0);
    // full swing, quarter-turn steps land one count short of the axes
    add_write(jstg_pkg::CFG_CENTER, 32'h0000_0000);
    repeat (4) add_tick(1'b0, 1'b0, 1'b0);

    // crossed limits
    add_write(jstg_pkg::CFG_LOWER, 32'd100);
    add_write(jstg_pkg::CFG_UPPER, 32'hFFFF_FF9C);
    add_tick(1'b0, 1'b0, 1'b0);
    add_tick(1'b0, 1'b0, 1'b0);

    // center above the upper limit: amplitude floors at zero
    add_write(jstg_pkg::CFG_LOWER, 32'hFFFF_CDBC);
    add_write(jstg_pkg::CFG_UPPER, 32'd12868);
    add_write(jstg_pkg::CFG_CENTER, 32'd20000);
    add_tick(1'b0, 1'b0, 1'b0);

    // zero preset, zero rate, zero step, half-turn offset
    add_write(jstg_pkg::CFG_CENTER, 32'd0);
    add_write(jstg_pkg::CFG_PRESET, 32'd0);
    add_write(jstg_pkg::CFG_RATE, 32'd0);
    add_write(jstg_pkg::CFG_STEP, 32'd0);
    add_write(jstg_pkg::CFG_OFFSET, 32'h8000_0000);
    add_tick(1'b0, 1'b0, 1'b0);
    add_tick(1'b0, 1'b0, 1'b0);

    // zero duration finishes at the first tick
    add_write(jstg_pkg::CFG_DURATION, 32'd0);
    add_tick(1'b1, 1'b0, 1'b0);
    add_tick(1'b0, 1'b0, 1'b0);

    // random phases: fresh settings, then mostly plain motion ticks
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      last = (ph == RANDOM_PHASES - 1);
      lo  = -int'($urandom_range(0, 24000));
      hi  = int'($urandom_range(0, 24000));
      ctr = lo + int'($urandom_range(0, hi - lo));
      if ($urandom_range(0, 5) == 0) ctr = int'($urandom);
      add_write(jstg_pkg::CFG_LOWER, ($urandom_range(0, 7) == 0) ? $urandom : 32'(lo));
      add_write(jstg_pkg::CFG_UPPER, ($urandom_range(0, 7) == 0) ? $urandom : 32'(hi));
      add_write(jstg_pkg::CFG_CENTER, 32'(ctr));
      add_write(jstg_pkg::CFG_PRESET,
                ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32767));
      add_write(jstg_pkg::CFG_STEP, $urandom);
      add_write(jstg_pkg::CFG_OFFSET, $urandom);
      add_write(jstg_pkg::CFG_RATE, $urandom);
      add_write(jstg_pkg::CFG_DURATION,
                ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 120));
      add_tick(1'b1, 1'b0, last);
      for (int k = 0; k < PHASE_TICKS; k++) begin
        if (ph == 2 && k == PHASE_TICKS / 2) begin
          tick_plan.push_back('{kind: ITEM_HOLD, restart: 1'b0, stop: 1'b0, calm: 1'b0,
                                idx: '0, data: '0});
        end
        r    = $urandom_range(0, 99);
        calm = last || ((k / 20) % 3 == 2);
        add_tick(r < 5, r >= 97, calm);
      end
    end

    // wait for the plan and the results to drain
    while (!(rst_ni && tick_plan.size() == 0 && !in_valid_i && sample_fifo.size() == 0))
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (sample_fifo.size() != 0) report_mismatch("results still outstanding", 0,
                                                 sample_fifo.size());
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
